// ===== rtl/core/wtdp_pkg.sv =====
`timescale 1ns / 1ps
package wtdp_pkg;
  localparam int NODE_W  = 6;   // node index field width
  localparam int COUNT_W = 7;   // node_count register width
  localparam int DIST_W  = 38;  // saturating distance width
  localparam int PRED_W  = 7;   // predecessor entry width
  localparam logic [PRED_W-1:0] NO_PRED  = {PRED_W{1'b1}};
  localparam logic [DIST_W-1:0] DIST_SAT = {DIST_W{1'b1}};

  // node memory entry: predecessor and distance
  typedef struct packed {
    logic [PRED_W-1:0] pred;
    logic [DIST_W-1:0] distance;
  } node_entry_t;
endpackage

// ===== rtl/core/weighted_tree_diameter_path.sv =====
`timescale 1ns / 1ps
// Channel   Handshake               Payload
// in_       start / busy            in_from_node, in_to_node, in_arc_weight, in_last_arc
// out_      out_valid (1 cycle)     out_path_node, out_diameter_length,
//                                   out_unreached_error, out_last_result
// cfg_      cfg_we                  cfg_node_count
//
// Arcs load one per cycle into the arc memory while busy is low.
// The arc marked last starts two Dijkstra sweeps: each settle step scans the
// node memory (states SELA, SELB per node), then scans the arc memory (ARCA,
// ARCB per arc, plus ARCC when an in-range arc leaves the settled node). The
// path then comes out one node per EMTA, EMTB pass through the node memory's
// read port. Reset is synchronous; the receiver cannot stall, so results are never held off.
module weighted_tree_diameter_path
  import wtdp_pkg::*;
#(
  parameter int MAX_NODES   = 64,
  parameter int MAX_ARCS    = 128,
  parameter int WEIGHT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [NODE_W-1:0]   in_from_node,
  input  logic [NODE_W-1:0]   in_to_node,
  input  logic [31:0]         in_arc_weight,
  input  logic                in_last_arc,
  output logic                out_valid,
  output logic [NODE_W-1:0]   out_path_node,
  output logic [DIST_W-1:0]   out_diameter_length,
  output logic                out_unreached_error,
  output logic                out_last_result,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_node_count
);
  localparam int NAW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int AAW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
  localparam int ACW = $clog2(MAX_ARCS + 1);
  localparam int LW  = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;
  localparam int AEW = 2 * NODE_W + LW;

  localparam logic [3:0] S_LOAD = 4'd0, S_INIT = 4'd1, S_SELA = 4'd2, S_SELB = 4'd3,
                         S_PICK = 4'd4, S_ARCA = 4'd5, S_ARCB = 4'd6, S_ARCC = 4'd7,
                         S_SEND = 4'd8, S_EMTA = 4'd9, S_EMTB = 4'd10, S_ERR = 4'd11;

  logic [3:0]           state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [ACW-1:0]       total_r, total_nxt;
  logic [MAX_NODES-1:0] reached_r, reached_nxt, done_r, done_nxt;
  logic                 second_r, second_nxt;
  logic [NODE_W-1:0]    src_r, src_nxt;
  logic [COUNT_W-1:0]   idx_r, idx_nxt;       // node scan index / path step count
  logic [ACW-1:0]       arc_r, arc_nxt;
  logic                 best_ok_r, best_ok_nxt;
  logic [NODE_W-1:0]    best_r, best_nxt;
  logic [DIST_W-1:0]    best_d_r, best_d_nxt;
  logic                 far_ok_r, far_ok_nxt;
  logic [NODE_W-1:0]    far_r, far_nxt;
  logic [DIST_W-1:0]    far_d_r, far_d_nxt;
  logic [NODE_W-1:0]    dst_r, dst_nxt;
  logic [LW-1:0]        len_r, len_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic [DIST_W-1:0]    diam_r, diam_nxt;

  logic                 ov_r, ov_nxt, oerr_r, oerr_nxt, olast_r, olast_nxt;
  logic [NODE_W-1:0]    onode_r, onode_nxt;
  logic [DIST_W-1:0]    odiam_r, odiam_nxt;

  // active node count, clamped to 1 .. MAX_NODES
  logic [COUNT_W-1:0] n_act;
  always_comb begin
    if (count_r == '0) n_act = COUNT_W'(1);
    else if (32'(count_r) > MAX_NODES) n_act = COUNT_W'(MAX_NODES);
    else n_act = count_r;
  end

  // arc memory
  logic           arc_we;
  logic [AAW-1:0] arc_raddr;
  logic [AEW-1:0] arc_rdata;
  wtdp_ram #(.WIDTH(AEW), .DEPTH(MAX_ARCS)) u_arc_ram (
    .clk(clk), .we(arc_we), .waddr(total_r[AAW-1:0]),
    .wdata({in_from_node, in_to_node, in_arc_weight[LW-1:0]}),
    .raddr(arc_raddr), .rdata(arc_rdata)
  );

  // node memory: distance and predecessor
  logic           node_we;
  logic [NAW-1:0] node_waddr, node_raddr;
  node_entry_t    node_wdata, node_rdata;
  wtdp_ram #(.WIDTH(PRED_W + DIST_W), .DEPTH(MAX_NODES)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .raddr(node_raddr), .rdata(node_rdata)
  );

  logic [NODE_W-1:0] a_src, a_dst;
  logic [LW-1:0]     a_len;
  assign a_src = arc_rdata[AEW-1 -: NODE_W];
  assign a_dst = arc_rdata[LW +: NODE_W];
  assign a_len = arc_rdata[LW-1:0];

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] nd;
  assign sum = {1'b0, best_d_r} + (DIST_W+1)'(len_r);
  assign nd  = sum[DIST_W] ? DIST_SAT : sum[DIST_W-1:0];

  logic all_reached;
  always_comb begin
    all_reached = 1'b1;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (i < 32'(n_act) && !reached_r[i]) all_reached = 1'b0;
    end
  end

  logic accept;
  assign accept = start && (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;   total_nxt = total_r;   reached_nxt = reached_r;
    done_nxt = done_r;     second_nxt = second_r; src_nxt = src_r;
    idx_nxt = idx_r;       arc_nxt = arc_r;       best_ok_nxt = best_ok_r;
    best_nxt = best_r;     best_d_nxt = best_d_r; far_ok_nxt = far_ok_r;
    far_nxt = far_r;       far_d_nxt = far_d_r;   dst_nxt = dst_r;
    len_nxt = len_r;       cur_nxt = cur_r;       diam_nxt = diam_r;
    ov_nxt = 1'b0;         oerr_nxt = 1'b0;       olast_nxt = 1'b0;
    onode_nxt = onode_r;   odiam_nxt = odiam_r;
    arc_we = 1'b0;         arc_raddr = arc_r[AAW-1:0];
    node_we = 1'b0;        node_waddr = src_r[NAW-1:0];
    node_wdata = '{pred: NO_PRED, distance: '0};
    node_raddr = idx_r[NAW-1:0];
    case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (32'(total_r) < MAX_ARCS) begin
            arc_we = 1'b1;
            total_nxt = total_r + ACW'(1);
          end
          if (in_last_arc) begin
            second_nxt = 1'b0;
            src_nxt = '0;
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        // seed the source entry, clear per-sweep flags
        node_we = 1'b1;
        reached_nxt = '0;
        reached_nxt[src_r[NAW-1:0]] = 1'b1;
        done_nxt = '0;
        far_ok_nxt = 1'b0;
        idx_nxt = '0;
        best_ok_nxt = 1'b0;
        state_nxt = S_SELA;
      end
      S_SELA: begin
        if (idx_r == n_act) state_nxt = S_PICK;
        else state_nxt = S_SELB;
      end
      S_SELB: begin
        if (reached_r[idx_r[NAW-1:0]] && !done_r[idx_r[NAW-1:0]] &&
            (!best_ok_r || node_rdata.distance < best_d_r)) begin
          best_ok_nxt = 1'b1;
          best_nxt = NODE_W'(idx_r);
          best_d_nxt = node_rdata.distance;
        end
        idx_nxt = idx_r + COUNT_W'(1);
        state_nxt = S_SELA;
      end
      S_PICK: begin
        if (!best_ok_r) begin
          state_nxt = S_SEND;
        end else begin
          done_nxt[best_r[NAW-1:0]] = 1'b1;
          // settled distances are final: track farthest here
          if (!far_ok_r || best_d_r > far_d_r ||
              (best_d_r == far_d_r && best_r < far_r)) begin
            far_ok_nxt = 1'b1;
            far_nxt = best_r;
            far_d_nxt = best_d_r;
          end
          arc_nxt = '0;
          state_nxt = S_ARCA;
        end
      end
      S_ARCA: begin
        if (arc_r == total_r) begin
          idx_nxt = '0;
          best_ok_nxt = 1'b0;
          state_nxt = S_SELA;
        end else begin
          state_nxt = S_ARCB;
        end
      end
      S_ARCB: begin
        dst_nxt = a_dst;
        len_nxt = a_len;
        node_raddr = a_dst[NAW-1:0];
        if (a_src == best_r && COUNT_W'(a_src) < n_act && COUNT_W'(a_dst) < n_act) begin
          state_nxt = S_ARCC;
        end else begin
          arc_nxt = arc_r + ACW'(1);
          state_nxt = S_ARCA;
        end
      end
      S_ARCC: begin
        if (!reached_r[dst_r[NAW-1:0]] || node_rdata.distance > nd) begin
          node_we = 1'b1;
          node_waddr = dst_r[NAW-1:0];
          node_wdata = '{pred: PRED_W'(best_r), distance: nd};
          reached_nxt[dst_r[NAW-1:0]] = 1'b1;
        end
        arc_nxt = arc_r + ACW'(1);
        state_nxt = S_ARCA;
      end
      S_SEND: begin
        if (!all_reached) begin
          state_nxt = S_ERR;
        end else if (!second_r) begin
          second_nxt = 1'b1;
          src_nxt = far_r;
          state_nxt = S_INIT;
        end else begin
          cur_nxt = far_r;
          diam_nxt = far_d_r;
          idx_nxt = '0;
          state_nxt = S_EMTA;
        end
      end
      S_EMTA: begin
        node_raddr = cur_r[NAW-1:0];
        state_nxt = S_EMTB;
      end
      S_EMTB: begin
        ov_nxt = 1'b1;
        onode_nxt = cur_r;
        odiam_nxt = diam_r;
        idx_nxt = idx_r + COUNT_W'(1);
        if (node_rdata.pred == NO_PRED || (idx_r + COUNT_W'(1)) >= n_act) begin
          olast_nxt = 1'b1;
          total_nxt = '0;
          state_nxt = S_LOAD;
        end else begin
          cur_nxt = node_rdata.pred[NODE_W-1:0];
          state_nxt = S_EMTA;
        end
      end
      S_ERR: begin
        ov_nxt = 1'b1;
        oerr_nxt = 1'b1;
        olast_nxt = 1'b1;
        onode_nxt = '0;
        odiam_nxt = '0;
        total_nxt = '0;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      total_r <= '0;
      reached_r <= '0;
      done_r <= '0;
      count_r <= COUNT_W'(1);
      ov_r <= 1'b0;
      oerr_r <= 1'b0;
      olast_r <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      reached_r <= reached_nxt;
      done_r <= done_nxt;
      if (cfg_we) count_r <= cfg_node_count;
      ov_r <= ov_nxt;
      oerr_r <= oerr_nxt;
      olast_r <= olast_nxt;
      second_r <= second_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r <= src_nxt;     idx_r <= idx_nxt;       arc_r <= arc_nxt;
    best_ok_r <= best_ok_nxt; best_r <= best_nxt; best_d_r <= best_d_nxt;
    far_ok_r <= far_ok_nxt;   far_r <= far_nxt;   far_d_r <= far_d_nxt;
    dst_r <= dst_nxt;     len_r <= len_nxt;       cur_r <= cur_nxt;
    diam_r <= diam_nxt;   onode_r <= onode_nxt;   odiam_r <= odiam_nxt;
  end

  assign busy                = (state_r != S_LOAD);
  assign out_valid           = ov_r;
  assign out_path_node       = onode_r;
  assign out_diameter_length = odiam_r;
  assign out_unreached_error = oerr_r;
  assign out_last_result     = olast_r;
endmodule

// ===== rtl/core/wtdp_ram.sv =====
`timescale 1ns / 1ps
module wtdp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
